// File: src/kdhr_pkg.sv
// Shared types and constants for the key debounce, hold and repeat block.
// Holds register indexes, event codes, reset values and the config bundle.
// No dependencies.
`default_nettype none
package kdhr_pkg;

	localparam int KDHR_NUM_KEYS = 6;
	localparam int CNT_W         = 15;
	localparam int PROD_W        = 38;
	localparam int RECIP_SH      = 26;
	localparam int RECIP_W       = 28;
	localparam int QUO_W         = 12;
	localparam int VOLT_W        = 15;
	localparam int LIMIT_W       = 12;
	localparam int PERIOD_W      = 4;
	localparam int EVCNT_W       = 4;
	localparam int MAX_EVENTS    = 14;
	localparam int VOLT_MUL      = 330 * 347;
	localparam int VOLT_DIV      = 1023 * 47;

	// ceil(VOLT_MUL * 2^RECIP_SH / VOLT_DIV); the error stays below 1/VOLT_DIV
	// for every 10-bit sample, so the shifted product is the exact floor quotient
	localparam logic [RECIP_W-1:0] VOLT_RECIP =
		RECIP_W'(((longint'(VOLT_MUL) << RECIP_SH) + longint'(VOLT_DIV) - longint'(1)) /
		longint'(VOLT_DIV));

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [CNT_W-1:0]    RST_PRESS        = 15'd2;
	localparam logic [CNT_W-1:0]    RST_HOLD_A       = 15'd50;
	localparam logic [CNT_W-1:0]    RST_HOLD_B       = 15'd200;
	localparam logic [CNT_W-1:0]    RST_HOLD_C       = 15'd500;
	localparam logic [CNT_W-1:0]    RST_HOLD_D       = 15'd1000;
	localparam logic [CNT_W-1:0]    RST_REPEAT_START = 15'd63;
	localparam logic [PERIOD_W-1:0] RST_PERIOD_LOG2  = 4'd3;
	localparam logic [LIMIT_W-1:0]  RST_LOW_LIMIT    = 12'd400;

	typedef enum logic [2:0] {
		REG_PRESS        = 3'd0,
		REG_HOLD_A       = 3'd1,
		REG_HOLD_B       = 3'd2,
		REG_HOLD_C       = 3'd3,
		REG_HOLD_D       = 3'd4,
		REG_REPEAT_START = 3'd5,
		REG_PERIOD_LOG2  = 3'd6,
		REG_LOW_LIMIT    = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		EV_STATUS   = 3'd0,
		EV_PRESSED  = 3'd1,
		EV_RELEASED = 3'd2,
		EV_HOLD_A   = 3'd3,
		EV_HOLD_B   = 3'd4,
		EV_HOLD_C   = 3'd5,
		EV_HOLD_D   = 3'd6,
		EV_REPEAT   = 3'd7
	} ev_kind_t;

	typedef struct packed {
		logic [CNT_W-1:0]    press_count;
		logic [CNT_W-1:0]    hold_count_a;
		logic [CNT_W-1:0]    hold_count_b;
		logic [CNT_W-1:0]    hold_count_c;
		logic [CNT_W-1:0]    hold_count_d;
		logic [CNT_W-1:0]    repeat_start;
		logic [PERIOD_W-1:0] repeat_period_log2;
	} key_cfg_t;

endpackage
`default_nettype wire

// File: src/kdhr_front.sv
// Front end: accepts one tick, scales the converter sample by a reciprocal multiply,
// updates the stored voltage and classifies the keys. Uses kdhr_pkg.
`default_nettype none
module kdhr_front import kdhr_pkg::*; #(
	parameter int NUM_KEYS = KDHR_NUM_KEYS
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire  [9:0]                adc_sample,
	input  wire  [4:0]                key_levels,
	input  wire                       remote_request,
	input  wire  [7:0]                remote_screen,
	input  wire  [7:0]                remote_key,
	input  wire  [LIMIT_W-1:0]        low_voltage_limit,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic [NUM_KEYS-1:0]       out_pressed,
	output logic                      out_request,
	output logic [7:0]                out_screen,
	output logic [7:0]                out_key,
	output logic [VOLT_W-1:0]         out_voltage
);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_MUL  = 4'b0010,
		F_CLS  = 4'b0100,
		F_PUSH = 4'b1000
	} front_state_t;

	front_state_t      state_q;
	logic [9:0]        adc_q;
	logic [QUO_W-1:0]  quo_q;
	logic [4:0]        levels_q;
	logic              req_q;
	logic [7:0]        scr_q;
	logic [7:0]        rkey_q;
	logic [VOLT_W-1:0] volt_q;
	logic              analog_q;
	logic [PROD_W-1:0] prod;

	assign prod        = PROD_W'(adc_q) * PROD_W'(VOLT_RECIP);
	assign in_ready    = (state_q == F_IDLE);
	assign out_valid   = (state_q == F_PUSH);
	assign out_request = req_q;
	assign out_screen  = scr_q;
	assign out_key     = rkey_q;
	assign out_voltage = volt_q;

	always_comb begin
		for (int i = 0; i < NUM_KEYS; i++) begin
			if (i == 0) begin
				out_pressed[i] = analog_q;
			end else if (i <= 5) begin
				out_pressed[i] = ~levels_q[i-1];
			end else begin
				out_pressed[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			volt_q  <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					state_q <= F_CLS;
				end
				F_CLS: begin
					if (quo_q > low_voltage_limit) begin
						volt_q <= VOLT_W'(quo_q) * VOLT_W'(10);
					end
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (out_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (in_valid) begin
					adc_q    <= adc_sample;
					levels_q <= key_levels;
					req_q    <= remote_request;
					scr_q    <= remote_screen;
					rkey_q   <= remote_key;
				end
			end
			F_MUL: begin
				quo_q <= prod[RECIP_SH +: QUO_W];
			end
			F_CLS: begin
				analog_q <= !(quo_q > low_voltage_limit);
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// File: src/kdhr_fifo.sv
// Small first-in first-out queue between the front end and the event sequencer.
// Generic width and depth, no package use.
`default_nettype none
module kdhr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              wr_valid,
	output logic             wr_ready,
	input  wire  [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  wire              rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             push;
	logic             pop;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

// File: src/kdhr_back.sv
// Event sequencer: walks the remote pair, each key's hold counter and the status result
// of a tick into an output register, at most one per cycle unless stalled. Uses kdhr_pkg.
`default_nettype none
module kdhr_back import kdhr_pkg::*; #(
	parameter int NUM_KEYS = KDHR_NUM_KEYS
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  key_cfg_t            cfg,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [NUM_KEYS-1:0] in_pressed,
	input  wire                 in_request,
	input  wire  [7:0]          in_screen,
	input  wire  [7:0]          in_key,
	input  wire  [VOLT_W-1:0]   in_voltage,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [2:0]          out_kind,
	output logic [7:0]          out_key,
	output logic                out_remote,
	output logic [7:0]          out_screen,
	output logic [VOLT_W-1:0]   out_voltage,
	output logic                out_last
);

	localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	typedef enum logic [5:0] {
		B_IDLE  = 6'b000001,
		B_REM_P = 6'b000010,
		B_REM_R = 6'b000100,
		B_KEY   = 6'b001000,
		B_REP   = 6'b010000,
		B_STAT  = 6'b100000
	} back_state_t;

	back_state_t         state_q;
	logic [CNT_W-1:0]    hold_q [NUM_KEYS];
	logic [NUM_KEYS-1:0] pressed_q;
	logic [7:0]          scr_q;
	logic [7:0]          rkey_q;
	logic [VOLT_W-1:0]   volt_q;
	logic [KW-1:0]       key_q;
	logic [EVCNT_W-1:0]  n_q;

	logic                can_emit;
	logic                step;
	logic [CNT_W-1:0]    cnt;
	logic [CNT_W-1:0]    cinc;
	logic [CNT_W-1:0]    cnt_next;
	logic                prs;
	logic                adv;
	logic                rel;
	logic                has_mark;
	ev_kind_t            mark_kind;
	logic [15:0]         mask;
	logic                rep;
	logic                second;
	logic                last_key;
	logic                ev_req;
	ev_kind_t            ev_kind;
	logic                ev_remote;
	logic                ev_last;
	logic                ev_keep;

	assign can_emit = !out_valid || out_ready;
	assign step     = can_emit && (state_q != B_IDLE);
	assign in_ready = (state_q == B_IDLE);
	assign last_key = (key_q == KW'(NUM_KEYS - 1));

	assign cnt      = hold_q[key_q];
	assign prs      = pressed_q[key_q];
	assign cinc     = cnt + CNT_W'(1);
	assign adv      = prs && (cnt != CNT_MAX);
	assign rel      = !prs && (cnt >= cfg.press_count);
	assign mask     = (16'd1 << cfg.repeat_period_log2) - 16'd1;
	assign rep      = (cinc > cfg.repeat_start) && ((cinc & mask[CNT_W-1:0]) == '0);
	assign second   = adv && has_mark && rep;
	assign cnt_next = !prs ? '0 : (adv ? cinc : cnt);

	always_comb begin
		has_mark  = 1'b1;
		mark_kind = EV_PRESSED;
		if (cinc == cfg.press_count) begin
			mark_kind = EV_PRESSED;
		end else if (cinc == cfg.hold_count_a) begin
			mark_kind = EV_HOLD_A;
		end else if (cinc == cfg.hold_count_b) begin
			mark_kind = EV_HOLD_B;
		end else if (cinc == cfg.hold_count_c) begin
			mark_kind = EV_HOLD_C;
		end else if (cinc == cfg.hold_count_d) begin
			mark_kind = EV_HOLD_D;
		end else begin
			has_mark = 1'b0;
		end
	end

	always_comb begin
		ev_req    = 1'b0;
		ev_kind   = EV_STATUS;
		ev_remote = 1'b0;
		ev_last   = 1'b0;
		case (state_q)
			B_REM_P: begin
				ev_req    = 1'b1;
				ev_kind   = EV_PRESSED;
				ev_remote = 1'b1;
			end
			B_REM_R: begin
				ev_req    = 1'b1;
				ev_kind   = EV_RELEASED;
				ev_remote = 1'b1;
			end
			B_KEY: begin
				if (rel) begin
					ev_req  = 1'b1;
					ev_kind = EV_RELEASED;
				end else if (adv && has_mark) begin
					ev_req  = 1'b1;
					ev_kind = mark_kind;
				end else if (adv && rep) begin
					ev_req  = 1'b1;
					ev_kind = EV_REPEAT;
				end
			end
			B_REP: begin
				ev_req  = 1'b1;
				ev_kind = EV_REPEAT;
			end
			B_STAT: begin
				ev_req  = 1'b1;
				ev_last = 1'b1;
			end
			default: begin
			end
		endcase
		ev_keep = ev_req && (ev_last || (n_q < EVCNT_W'(MAX_EVENTS)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			out_valid <= 1'b0;
			n_q       <= '0;
			key_q     <= '0;
			for (int i = 0; i < NUM_KEYS; i++) begin
				hold_q[i] <= '0;
			end
		end else begin
			if (can_emit) begin
				out_valid <= step && ev_keep;
			end
			if (step && ev_keep && !ev_last) begin
				n_q <= n_q + EVCNT_W'(1);
			end
			case (state_q)
				B_IDLE: begin
					if (in_valid) begin
						n_q     <= '0;
						key_q   <= '0;
						state_q <= in_request ? B_REM_P : B_KEY;
					end
				end
				B_REM_P: begin
					if (step) begin
						state_q <= B_REM_R;
					end
				end
				B_REM_R: begin
					if (step) begin
						state_q <= B_KEY;
					end
				end
				B_KEY: begin
					if (step) begin
						hold_q[key_q] <= cnt_next;
						if (second) begin
							state_q <= B_REP;
						end else if (last_key) begin
							state_q <= B_STAT;
						end else begin
							key_q <= key_q + KW'(1);
						end
					end
				end
				B_REP: begin
					if (step) begin
						if (last_key) begin
							state_q <= B_STAT;
						end else begin
							key_q   <= key_q + KW'(1);
							state_q <= B_KEY;
						end
					end
				end
				B_STAT: begin
					if (step) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && in_valid) begin
			pressed_q <= in_pressed;
			scr_q     <= in_screen;
			rkey_q    <= in_key;
			volt_q    <= in_voltage;
		end
		if (step) begin
			out_kind    <= ev_kind;
			out_key     <= ev_remote ? rkey_q : (ev_last ? 8'd0 : 8'(key_q));
			out_remote  <= ev_remote;
			out_screen  <= ev_remote ? scr_q : 8'd0;
			out_voltage <= volt_q;
			out_last    <= ev_last;
		end
	end

endmodule
`default_nettype wire

// File: src/key_debounce_hold_repeat.sv
// Top level of the key debounce, hold and repeat block: config registers,
// front end, tick queue and event sequencer. Uses kdhr_pkg and all kdhr_* modules.
//
// channel  dir  handshake         payload
// s_axis   in   s_tvalid/tready   tdata: sample, levels, screen, key; tuser: request
// m_axis   out  m_tvalid/tready   tdata: key, remote, screen, voltage; tuser: kind
// cfg      in   cfg_we            cfg_index, cfg_data
//
// Front end takes a tick through accept, reciprocal multiply, classify and push.
// The sequencer steps through accept, the remote pair when requested, each key, an extra
// step for a key that adds a repeat to a pressed or hold event, and status, with
// one result per cycle at most; the sequencer sets the tick rate.
// Reset clears hold counters, stored voltage and registers to defaults at once.
// A stalled output holds the sequencer; the queue lets the front end keep working.
`default_nettype none
module key_debounce_hold_repeat import kdhr_pkg::*; #(
	parameter int NUM_KEYS = KDHR_NUM_KEYS
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // adc_sample[9:0], key_levels[14:10],
	                               // remote_screen[22:15], remote_key[30:23], zero
	input  wire  [0:0]  s_tuser,   // remote_request
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // key_index[7:0], from_remote[8],
	                               // screen_number[16:9], voltage_mv[31:17]
	output logic [2:0]  m_tuser,   // event_kind
	output logic        m_tlast,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [14:0] cfg_data
);

	localparam int ITEM_W = NUM_KEYS + 1 + 8 + 8 + VOLT_W;

	key_cfg_t            cfg_q;
	logic [LIMIT_W-1:0]  limit_q;

	logic                f_valid;
	logic                f_ready;
	logic [NUM_KEYS-1:0] f_pressed;
	logic                f_request;
	logic [7:0]          f_screen;
	logic [7:0]          f_key;
	logic [VOLT_W-1:0]   f_voltage;
	logic [ITEM_W-1:0]   q_wdata;
	logic [ITEM_W-1:0]   q_rdata;
	logic                q_valid;
	logic                q_ready;

	logic [7:0]          o_key;
	logic                o_remote;
	logic [7:0]          o_screen;
	logic [VOLT_W-1:0]   o_voltage;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_count        <= RST_PRESS;
			cfg_q.hold_count_a       <= RST_HOLD_A;
			cfg_q.hold_count_b       <= RST_HOLD_B;
			cfg_q.hold_count_c       <= RST_HOLD_C;
			cfg_q.hold_count_d       <= RST_HOLD_D;
			cfg_q.repeat_start       <= RST_REPEAT_START;
			cfg_q.repeat_period_log2 <= RST_PERIOD_LOG2;
			limit_q                  <= RST_LOW_LIMIT;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PRESS:        cfg_q.press_count        <= cfg_data;
				REG_HOLD_A:       cfg_q.hold_count_a       <= cfg_data;
				REG_HOLD_B:       cfg_q.hold_count_b       <= cfg_data;
				REG_HOLD_C:       cfg_q.hold_count_c       <= cfg_data;
				REG_HOLD_D:       cfg_q.hold_count_d       <= cfg_data;
				REG_REPEAT_START: cfg_q.repeat_start       <= cfg_data;
				REG_PERIOD_LOG2:  cfg_q.repeat_period_log2 <= cfg_data[PERIOD_W-1:0];
				REG_LOW_LIMIT:    limit_q                  <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	kdhr_front #(
		.NUM_KEYS(NUM_KEYS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (s_tvalid),
		.in_ready         (s_tready),
		.adc_sample       (s_tdata[9:0]),
		.key_levels       (s_tdata[14:10]),
		.remote_request   (s_tuser[0]),
		.remote_screen    (s_tdata[22:15]),
		.remote_key       (s_tdata[30:23]),
		.low_voltage_limit(limit_q),
		.out_valid        (f_valid),
		.out_ready        (f_ready),
		.out_pressed      (f_pressed),
		.out_request      (f_request),
		.out_screen       (f_screen),
		.out_key          (f_key),
		.out_voltage      (f_voltage)
	);

	assign q_wdata = {f_voltage, f_key, f_screen, f_request, f_pressed};

	kdhr_fifo #(
		.WIDTH(ITEM_W),
		.DEPTH(2)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_data (q_wdata),
		.rd_valid(q_valid),
		.rd_ready(q_ready),
		.rd_data (q_rdata)
	);

	kdhr_back #(
		.NUM_KEYS(NUM_KEYS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (q_valid),
		.in_ready   (q_ready),
		.in_pressed (q_rdata[NUM_KEYS-1:0]),
		.in_request (q_rdata[NUM_KEYS]),
		.in_screen  (q_rdata[NUM_KEYS+8:NUM_KEYS+1]),
		.in_key     (q_rdata[NUM_KEYS+16:NUM_KEYS+9]),
		.in_voltage (q_rdata[ITEM_W-1:NUM_KEYS+17]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (m_tuser),
		.out_key    (o_key),
		.out_remote (o_remote),
		.out_screen (o_screen),
		.out_voltage(o_voltage),
		.out_last   (m_tlast)
	);

	assign m_tdata = {o_voltage, o_screen, o_remote, o_key};

endmodule
`default_nettype wire

// File: tb/key_debounce_hold_repeat_tb.sv
// Testbench for key_debounce_hold_repeat: directed and random ticks, config phases at the
// extremes, a long hold of every key; results are checked against a local model.
// Depends on kdhr_pkg and the key_debounce_hold_repeat RTL.
`timescale 1ns / 1ps
module key_debounce_hold_repeat_tb;
	import kdhr_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int QUIET       = 40;
	localparam int HOLD_TICKS  = 10;

	typedef struct {
		ev_kind_t          kind;
		logic [7:0]        key_idx;
		logic              remote;
		logic [7:0]        screen;
		logic [VOLT_W-1:0] volt_mv;
		logic              last;
	} key_event_t;

	class key_event_model;
		logic [CNT_W-1:0]    hold_cnt [KDHR_NUM_KEYS];
		logic [VOLT_W-1:0]   volt_mv;
		logic [CNT_W-1:0]    press_count, hold_a, hold_b, hold_c, hold_d, repeat_start;
		logic [PERIOD_W-1:0] period_log2;
		logic [LIMIT_W-1:0]  low_limit;
		key_event_t          expected_events [$];
		int                  tick_events;
		int                  seen;

		function new();
			foreach (hold_cnt[i])
				hold_cnt[i] = '0;
			volt_mv      = '0;
			press_count  = RST_PRESS;
			hold_a       = RST_HOLD_A;
			hold_b       = RST_HOLD_B;
			hold_c       = RST_HOLD_C;
			hold_d       = RST_HOLD_D;
			repeat_start = RST_REPEAT_START;
			period_log2  = RST_PERIOD_LOG2;
			low_limit    = RST_LOW_LIMIT;
			seen         = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [CNT_W-1:0] val);
			case (idx)
			REG_PRESS:        press_count  = val;
			REG_HOLD_A:       hold_a       = val;
			REG_HOLD_B:       hold_b       = val;
			REG_HOLD_C:       hold_c       = val;
			REG_HOLD_D:       hold_d       = val;
			REG_REPEAT_START: repeat_start = val;
			REG_PERIOD_LOG2:  period_log2  = val[PERIOD_W-1:0];
			REG_LOW_LIMIT:    low_limit    = val[LIMIT_W-1:0];
			default: ;
			endcase
		endfunction

		function void add_event(ev_kind_t kind, logic [7:0] key_idx, logic remote,
				logic [7:0] screen);
			key_event_t e;
			if (tick_events >= MAX_EVENTS)
				return;
			e.kind    = kind;
			e.key_idx = key_idx;
			e.remote  = remote;
			e.screen  = screen;
			e.volt_mv = volt_mv;
			e.last    = 1'b0;
			expected_events.push_back(e);
			tick_events++;
		endfunction

		function void note_tick(logic [9:0] adc, logic [4:0] levels, logic req,
				logic [7:0] scr, logic [7:0] rkey);
			int unsigned v;
			int unsigned mask;
			int unsigned c;
			logic        analog_low;
			logic        pressed;
			logic        advanced;
			key_event_t  e;
			tick_events = 0;
			v = (32'(adc) * VOLT_MUL) / VOLT_DIV;
			analog_low = (v <= low_limit);
			if (!analog_low)
				volt_mv = VOLT_W'(v * 10);
			if (req) begin
				add_event(EV_PRESSED, rkey, 1'b1, scr);
				add_event(EV_RELEASED, rkey, 1'b1, scr);
			end
			mask = (1 << period_log2) - 1;
			for (int i = 0; i < KDHR_NUM_KEYS; i++) begin
				if (i == 0)
					pressed = analog_low;
				else if (i <= 5)
					pressed = !levels[i-1];
				else
					pressed = 1'b0;
				advanced = 1'b0;
				if (pressed) begin
					if (hold_cnt[i] != CNT_MAX) begin
						hold_cnt[i] = hold_cnt[i] + 1'b1;
						advanced = 1'b1;
					end
				end else begin
					if (hold_cnt[i] >= press_count)
						add_event(EV_RELEASED, 8'(i), 1'b0, 8'd0);
					hold_cnt[i] = '0;
				end
				if (advanced) begin
					c = hold_cnt[i];
					if (c == press_count)
						add_event(EV_PRESSED, 8'(i), 1'b0, 8'd0);
					else if (c == hold_a)
						add_event(EV_HOLD_A, 8'(i), 1'b0, 8'd0);
					else if (c == hold_b)
						add_event(EV_HOLD_B, 8'(i), 1'b0, 8'd0);
					else if (c == hold_c)
						add_event(EV_HOLD_C, 8'(i), 1'b0, 8'd0);
					else if (c == hold_d)
						add_event(EV_HOLD_D, 8'(i), 1'b0, 8'd0);
					if (c > repeat_start && (c & mask) == 0)
						add_event(EV_REPEAT, 8'(i), 1'b0, 8'd0);
				end
			end
			e.kind    = EV_STATUS;
			e.key_idx = 8'd0;
			e.remote  = 1'b0;
			e.screen  = 8'd0;
			e.volt_mv = volt_mv;
			e.last    = 1'b1;
			expected_events.push_back(e);
		endfunction

		function string check_event(logic [2:0] kind, logic [7:0] key_idx, logic remote,
				logic [7:0] screen, logic [VOLT_W-1:0] mv, logic last);
			key_event_t e;
			seen++;
			if (expected_events.size() == 0)
				return $sformatf("result %0d arrived with nothing expected", seen);
			e = expected_events.pop_front();
			if (kind !== e.kind || key_idx !== e.key_idx || remote !== e.remote ||
					screen !== e.screen || mv !== e.volt_mv || last !== e.last)
				return $sformatf({"result %0d: got kind %0d key %0d rem %0b scr %0d mv %0d",
					" last %0b, want kind %0d key %0d rem %0b scr %0d mv %0d last %0b"},
					seen, kind, key_idx, remote, screen, mv, last,
					e.kind, e.key_idx, e.remote, e.screen, e.volt_mv, e.last);
			return "";
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;
	logic [0:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [14:0] cfg_data  = '0;

	key_event_model model = new();
	int             mismatches  = 0;
	int             idle_cycles = 0;
	int             rx_hold     = 0;
	bit             no_idle     = 1'b0;
	logic [4:0]     rand_levels = 5'h1f;
	bit             low_mode    = 1'b0;

	key_debounce_hold_repeat i_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("mismatch: %s", msg);
	endtask

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		string msg;
		if (arst_n && m_tvalid && m_tready) begin
			msg = model.check_event(m_tuser, m_tdata[7:0], m_tdata[8], m_tdata[16:9],
				m_tdata[31:17], m_tlast);
			if (msg != "")
				report_mismatch(msg);
		end
		if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			rx_hold = pick_gap();
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[key_debounce_hold_repeat] ERROR");
			$finish;
		end
	end

	task automatic send_tick(input logic [9:0] adc, input logic [4:0] levels, input logic req,
			input logic [7:0] scr, input logic [7:0] rkey);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, rkey, scr, levels, adc};
		s_tuser  <= req;
		do
			@(posedge clk);
		while (!s_tready);
		model.note_tick(adc, levels, req, scr, rkey);
	endtask

	task automatic drop_valid();
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (model.expected_events.size() != 0);
	endtask

	task automatic settle();
		drop_valid();
		wait_drained();
		repeat (QUIET) @(posedge clk);
	endtask

	task automatic load_config(input int p, input int a, input int b, input int c, input int d,
			input int s, input int per, input int lim);
		logic [CNT_W-1:0] vals [8];
		reg_idx_t         idx;
		vals[REG_PRESS]        = CNT_W'(p);
		vals[REG_HOLD_A]       = CNT_W'(a);
		vals[REG_HOLD_B]       = CNT_W'(b);
		vals[REG_HOLD_C]       = CNT_W'(c);
		vals[REG_HOLD_D]       = CNT_W'(d);
		vals[REG_REPEAT_START] = CNT_W'(s);
		vals[REG_PERIOD_LOG2]  = CNT_W'(per);
		vals[REG_LOW_LIMIT]    = CNT_W'(lim);
		idx = idx.first();
		repeat (8) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= vals[idx];
			@(posedge clk);
			model.write_reg(idx, vals[idx]);
			idx = idx.next();
		end
		cfg_we <= 1'b0;
	endtask

	// mostly slow-moving key levels so holds build up, with some fully random noise
	task automatic run_random(input int n_items);
		int         thr;
		logic [9:0] adc;
		for (int k = 0; k < n_items; k++) begin
			if ($urandom_range(0, 29) == 0) begin
				drop_valid();
				wait_drained();
			end
			if ($urandom_range(0, 9) == 0)
				rand_levels = 5'($urandom);
			else
				for (int b = 0; b < 5; b++)
					if ($urandom_range(0, 7) == 0)
						rand_levels[b] = ~rand_levels[b];
			if ($urandom_range(0, 7) == 0)
				low_mode = ~low_mode;
			thr = (int'(model.low_limit) * 1023) / 2436;
			if (thr > 1023)
				thr = 1023;
			if (low_mode || thr >= 1023)
				adc = 10'($urandom_range(0, thr));
			else
				adc = 10'($urandom_range(thr + 1, 1023));
			send_tick(adc, rand_levels, ($urandom_range(0, 4) == 0), 8'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		int p, a, b, c, d;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// defaults: analog key at the limit boundary, remote extremes, press and release
		send_tick(10'd0,    5'h1f, 1'b0, 8'h00, 8'h00);
		send_tick(10'd0,    5'h1f, 1'b0, 8'h00, 8'h00);
		send_tick(10'd1023, 5'h1f, 1'b1, 8'hff, 8'hff);
		send_tick(10'd1023, 5'h00, 1'b1, 8'h00, 8'h00);
		send_tick(10'd1023, 5'h00, 1'b0, 8'h00, 8'h00);
		send_tick(10'd168,  5'h15, 1'b1, 8'haa, 8'h55);
		send_tick(10'd169,  5'h0a, 1'b1, 8'h55, 8'haa);
		send_tick(10'd512,  5'h1f, 1'b0, 8'h00, 8'h00);
		send_tick(10'd1022, 5'h1f, 1'b1, 8'h0f, 8'hf0);
		send_tick(10'd1,    5'h00, 1'b0, 8'h00, 8'h00);
		send_tick(10'd1,    5'h00, 1'b0, 8'h00, 8'h00);
		send_tick(10'd1023, 5'h1f, 1'b0, 8'h00, 8'h00);

		settle();
		load_config(1, 2, 3, 4, 5, 0, 0, 0);
		run_random(30);

		// zero press and hold counts: releases on every idle tick, no pressed or hold events
		settle();
		load_config(0, 0, 0, 0, 0, 0, 1, 2436);
		run_random(25);

		repeat (4) begin
			settle();
			p = $urandom_range(1, 4);
			a = p + $urandom_range(0, 4);
			b = a + $urandom_range(0, 4);
			c = b + $urandom_range(0, 6);
			d = c + $urandom_range(0, 8);
			load_config(p, a, b, c, d, $urandom_range(0, 16), $urandom_range(0, 4),
				$urandom_range(0, 2436));
			run_random(30);
		end

		// top of every range; period beyond the counter width never repeats
		settle();
		load_config(32767, 32767, 32767, 32767, 32767, 32767, 15, 4095);
		run_random(20);

		// hold every key with repeats on so a tick can carry the most events, then let go
		settle();
		load_config(2, 4, 3, 0, 7, 3, 1, 0);
		no_idle = 1'b1;
		for (int k = 0; k < HOLD_TICKS; k++)
			send_tick(10'd0, 5'h00, ($urandom_range(0, 1) == 0), 8'($urandom), 8'($urandom));
		send_tick(10'd1023, 5'h1f, 1'b0, 8'h00, 8'h00);
		no_idle = 1'b0;

		settle();
		load_config(int'(RST_PRESS), int'(RST_HOLD_A), int'(RST_HOLD_B), int'(RST_HOLD_C),
			int'(RST_HOLD_D), int'(RST_REPEAT_START), int'(RST_PERIOD_LOG2),
			int'(RST_LOW_LIMIT));
		run_random(20);

		settle();
		if (mismatches == 0)
			$display("[key_debounce_hold_repeat] OK");
		else
			$display("[key_debounce_hold_repeat] ERROR");
		$finish;
	end
endmodule
